// ===== design/floor_request_dispatcher_assert.svh =====
// Assertion macros shared by the checker.
`ifndef FLOOR_REQUEST_DISPATCHER_ASSERT_SVH
`define FLOOR_REQUEST_DISPATCHER_ASSERT_SVH

// Checked at every clk edge outside reset.
`define FRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clk edge, reset included.
`define FRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/frd_pkg.sv =====
package frd_pkg;

  localparam int ID_W      = 11;
  localparam int CMD_W     = 2;
  localparam int FLOOR_W   = 2;
  localparam int BYTE_W    = 8;
  localparam int PAYLOAD_W = FLOOR_W + 1;
  localparam int REG_IDX_W = 3;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int OPQ_DEPTH       = 2;

  // enable bit inside the first data byte of a status frame
  localparam int ENABLE_BIT_POS = 2;

  localparam logic [CMD_W-1:0] CMD_WEB = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CAN = 2'd1;

  localparam logic [REG_IDX_W-1:0] REG_TX_ID          = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ELEVATOR_ID    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CAR_ID         = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FLOOR_ONE_ID   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FLOOR_TWO_ID   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FLOOR_THREE_ID = 3'd5;

  localparam logic [ID_W-1:0] TX_ID_RST          = 11'h100;
  localparam logic [ID_W-1:0] ELEVATOR_ID_RST    = 11'h101;
  localparam logic [ID_W-1:0] CAR_ID_RST         = 11'h200;
  localparam logic [ID_W-1:0] FLOOR_ONE_ID_RST   = 11'h201;
  localparam logic [ID_W-1:0] FLOOR_TWO_ID_RST   = 11'h202;
  localparam logic [ID_W-1:0] FLOOR_THREE_ID_RST = 11'h203;

  localparam logic [FLOOR_W-1:0] FLOOR_ONE   = 2'd1;
  localparam logic [FLOOR_W-1:0] FLOOR_TWO   = 2'd2;
  localparam logic [FLOOR_W-1:0] FLOOR_THREE = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0] tx_id;
    logic [ID_W-1:0] elevator_id;
    logic [ID_W-1:0] car_id;
    logic [ID_W-1:0] floor_one_id;
    logic [ID_W-1:0] floor_two_id;
    logic [ID_W-1:0] floor_three_id;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_RELEASE
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [FLOOR_W-1:0]  floor;
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_RESULT
  } back_state_t;

endpackage

// ===== design/frd_if.sv =====
interface frd_req_if import frd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [FLOOR_W-1:0] web_floor;
  logic [ID_W-1:0]    frame_id;
  logic [BYTE_W-1:0]  first_byte;

  modport source (output valid, cmd, web_floor, frame_id, first_byte, input ready);
  modport sink   (input valid, cmd, web_floor, frame_id, first_byte, output ready);
endinterface

interface frd_res_if import frd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 is_command;
  logic [ID_W-1:0]      out_id;
  logic [PAYLOAD_W-1:0] payload;
  logic                 dropped;

  modport source (output valid, is_command, out_id, payload, dropped, input ready);
  modport sink   (input valid, is_command, out_id, payload, dropped, output ready);
endinterface

// ===== design/frd_ram.sv =====
module frd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/frd_front.sv =====
module frd_front import frd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  frd_req_if.sink       req,
  input  cfg_t          cfg,
  output logic          op_valid,
  output op_t           op,
  input  logic          op_ready
);

  localparam int QPTR_W = $clog2(OPQ_DEPTH);
  localparam int QCNT_W = $clog2(OPQ_DEPTH + 1);

  op_t               q [OPQ_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  op_t               cls;
  logic              push;
  logic              pop;

  // decode one event into a queue operation; identifier priority follows
  // car, floor one, two, three, then elevator status
  always_comb begin
    cls.kind  = OP_NONE;
    cls.floor = '0;
    if (req.cmd == CMD_WEB) begin
      cls.kind  = OP_PUSH;
      cls.floor = req.web_floor;
    end else if (req.cmd == CMD_CAN) begin
      if (req.frame_id == cfg.car_id) begin
        cls.kind  = OP_PUSH;
        cls.floor = req.first_byte[FLOOR_W-1:0];
      end else if (req.frame_id == cfg.floor_one_id) begin
        cls.kind  = OP_PUSH;
        cls.floor = FLOOR_ONE;
      end else if (req.frame_id == cfg.floor_two_id) begin
        cls.kind  = OP_PUSH;
        cls.floor = FLOOR_TWO;
      end else if (req.frame_id == cfg.floor_three_id) begin
        cls.kind  = OP_PUSH;
        cls.floor = FLOOR_THREE;
      end else if (req.frame_id == cfg.elevator_id && !req.first_byte[ENABLE_BIT_POS]) begin
        cls.kind = OP_RELEASE;
      end
    end
  end

  assign req.ready = (count != QCNT_W'(OPQ_DEPTH));
  assign op_valid  = (count != '0);
  assign op        = q[rptr];
  assign push      = req.valid && req.ready;
  assign pop       = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(OPQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(OPQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cls;
    end
  end

endmodule

// ===== design/frd_back.sv =====
module frd_back import frd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  input  op_t              op,
  output logic             op_ready,
  input  logic [ID_W-1:0]  tx_id,
  frd_res_if.source        res
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  back_state_t        state;
  back_state_t        state_next;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [CNT_W-1:0]   fill;
  logic               busy;

  logic               take;
  logic               load;
  logic               do_push;
  logic               drop_now;
  logic               busy_after;
  logic               disp_now;
  logic [CNT_W-1:0]   fill_after;
  logic [FLOOR_W-1:0] ram_q;

  // latched between the two steps of one operation
  logic               disp;
  logic               drop;
  logic               bypass;
  logic [FLOOR_W-1:0] bypass_floor;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (op_valid) begin
          state_next = BK_RESULT;
        end
      end
      BK_RESULT: begin
        if (!res.valid || res.ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    op_ready = 1'b0;
    load     = 1'b0;
    case (state)
      BK_IDLE:   op_ready = 1'b1;
      BK_RESULT: load     = !res.valid || res.ready;
      default: begin
        op_ready = 1'b0;
        load     = 1'b0;
      end
    endcase
  end

  assign take       = op_valid && op_ready;
  assign do_push    = (op.kind == OP_PUSH) && (fill != CNT_W'(QUEUE_DEPTH));
  assign drop_now   = (op.kind == OP_PUSH) && (fill == CNT_W'(QUEUE_DEPTH));
  assign busy_after = (op.kind == OP_RELEASE) ? 1'b0 : busy;
  assign fill_after = fill + CNT_W'(do_push);
  assign disp_now   = (op.kind != OP_NONE) && !busy_after && (fill_after != '0);

  frd_ram #(
    .WIDTH (FLOOR_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .wr_en   (take && do_push),
    .wr_addr (wr_ptr),
    .wr_data (op.floor),
    .rd_en   (take && disp_now),
    .rd_addr (rd_ptr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      fill      <= '0;
      busy      <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        if (do_push) begin
          wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        end
        if (disp_now) begin
          rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        end
        fill <= fill_after - CNT_W'(disp_now);
        busy <= disp_now || busy_after;
      end
      if (load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      disp         <= disp_now;
      drop         <= drop_now;
      // empty queue: the entry popped is the one written in the same cycle
      bypass       <= (fill == '0);
      bypass_floor <= op.floor;
    end
    if (load) begin
      res.is_command <= disp;
      res.out_id     <= disp ? tx_id : '0;
      res.payload    <= disp ? {1'b1, (bypass ? bypass_floor : ram_q)} : '0;
      res.dropped    <= drop;
    end
  end

endmodule

// ===== design/floor_request_dispatcher.sv =====
// Channel   Dir  Transaction carries
// req       in   cmd, web_floor, frame_id, first_byte
// res       out  is_command, out_id, payload, dropped
// cfg_*     in   cfg_index, cfg_data (write only)
//
// Each event gives one result; the back end does a queue update
// plus floor RAM read, then an output register load, before the next.
// The front end takes an event every cycle while its two-entry queue has
// room, so it can accept while the back end works or the result waits.
// Reset is synchronous; floor RAM contents are not cleared.
// A stalled res holds its result and stops the back end after one more op.
module floor_request_dispatcher import frd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  frd_req_if.sink              req,
  frd_res_if.source            res,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]      cfg_data
);

  cfg_t cfg;
  logic op_valid;
  logic op_ready;
  op_t  op;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tx_id          <= TX_ID_RST;
      cfg.elevator_id    <= ELEVATOR_ID_RST;
      cfg.car_id         <= CAR_ID_RST;
      cfg.floor_one_id   <= FLOOR_ONE_ID_RST;
      cfg.floor_two_id   <= FLOOR_TWO_ID_RST;
      cfg.floor_three_id <= FLOOR_THREE_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TX_ID:          cfg.tx_id          <= cfg_data;
        REG_ELEVATOR_ID:    cfg.elevator_id    <= cfg_data;
        REG_CAR_ID:         cfg.car_id         <= cfg_data;
        REG_FLOOR_ONE_ID:   cfg.floor_one_id   <= cfg_data;
        REG_FLOOR_TWO_ID:   cfg.floor_two_id   <= cfg_data;
        REG_FLOOR_THREE_ID: cfg.floor_three_id <= cfg_data;
        default: ;
      endcase
    end
  end

  frd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg      (cfg),
    .op_valid (op_valid),
    .op       (op),
    .op_ready (op_ready)
  );

  frd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .op_ready (op_ready),
    .tx_id    (cfg.tx_id),
    .res      (res)
  );

endmodule

// ===== design/frd_checker.sv =====
`include "floor_request_dispatcher_assert.svh"

module frd_checker import frd_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_ready,
  input logic                 res_is_command,
  input logic [ID_W-1:0]      res_out_id,
  input logic [PAYLOAD_W-1:0] res_payload,
  input logic                 res_dropped
);

  `FRD_ASSERT_ALWAYS(a_reset_clears_res, rst |=> !res_valid, "res valid after reset")

  `FRD_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_is_command) && $stable(res_out_id) && $stable(res_payload) && $stable(res_dropped), "stalled result changed")

  `FRD_ASSERT(a_idle_zero, res_valid && !res_is_command |-> res_out_id == '0 && res_payload == '0, "idle report not zero")

  `FRD_ASSERT(a_cmd_enable, res_valid && res_is_command |-> res_payload[PAYLOAD_W-1], "command without enable bit")

endmodule

bind floor_request_dispatcher frd_checker u_frd_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_is_command (res.is_command),
  .res_out_id     (res.out_id),
  .res_payload    (res.payload),
  .res_dropped    (res.dropped)
);
